/* design/rsi_pkg.sv */
// Shared constants for the relative strength index unit.
package rsi_pkg;

   // Fixed field widths of the ports
   localparam int PRICE_WIDTH  = 32;
   localparam int PERIOD_WIDTH = 16;
   localparam int RSI_WIDTH    = 15;

   // Defaults for the top-level parameters
   localparam int PRICE_BITS_DEFAULT    = 32;
   localparam int FRACTION_BITS_DEFAULT = 16;

   // Period after reset
   localparam logic [PERIOD_WIDTH-1:0] PERIOD_RESET = 16'd14;

   // RSI full scale (100 * 256) and the bit-serial ratio walk over its bits
   localparam logic [RSI_WIDTH-1:0] RSI_SCALE = 15'd25600;
   localparam int RATIO_IDX_WIDTH = $clog2(RSI_WIDTH);
   localparam logic [RATIO_IDX_WIDTH-1:0] RATIO_TOP = RATIO_IDX_WIDTH'(RSI_WIDTH - 1);

endpackage

/* design/rsi_csub.sv */
// Shared compare-and-subtract unit: a - b and the a >= b flag.
module rsi_csub #(
   parameter int W = 58
) (
   input  logic [W-1:0] a,
   input  logic [W-1:0] b,
   output logic [W-1:0] diff,
   output logic         ge
);

   logic borrow;

   // One wide subtract; the borrow out is the compare result
   assign {borrow, diff} = {1'b0, a} - {1'b0, b};
   assign ge = ~borrow;

endmodule

/* design/relative_strength_index_unit.sv */
// Wilder RSI unit: one price per request, one RSI result per price once warmed up.
//
// Each request carries one unsigned price. The first price of a series (after reset, a
// period write or a request with series_start set) is stored and gives no result; the
// next period-1 prices only add their gains and losses. From the period-th change on,
// every price gives one result, rsi_value = floor(25600*G/(G+L)), and keeps the sequencer
// busy until that result is in the output register. Each division walks the DW =
// min(PRICE_BITS, 32) + 16 + FRACTION_BITS bits of its dividend, and the ratio walk is
// skipped when the average loss is zero. The work is done by one compare-and-subtract
// unit that a small sequencer runs for two restoring divisions by the period, one bit
// per cycle (gain average, then loss average), followed by a 15-step ratio walk over
// the bits of 25600 plus one extra step for each of its three set bits. The request
// side is ready only while the sequencer is idle; a finished result waits in an output
// register, so the next request is taken while it has not been collected. Zero average
// loss gives exactly 25600. A period of zero acts as one.
module relative_strength_index_unit #(
   parameter int PRICE_BITS    = rsi_pkg::PRICE_BITS_DEFAULT,
   parameter int FRACTION_BITS = rsi_pkg::FRACTION_BITS_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [rsi_pkg::PRICE_WIDTH-1:0]     req_price,
   input  logic                                req_series_start,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [rsi_pkg::RSI_WIDTH-1:0]       rsp_rsi_value,
   input  logic                                csr_write_enable,
   input  logic [rsi_pkg::PERIOD_WIDTH-1:0]    csr_write_data
);

   // Widths
   localparam int PW  = (PRICE_BITS < rsi_pkg::PRICE_WIDTH) ? PRICE_BITS : rsi_pkg::PRICE_WIDTH;
   localparam int FW  = FRACTION_BITS;
   localparam int NW  = rsi_pkg::PERIOD_WIDTH;
   localparam int AW  = PW + ((FW > NW) ? FW : NW);
   localparam int DW  = PW + NW + FW;
   localparam int UW  = AW + 2;
   localparam int CW  = $clog2(DW);
   localparam int RW  = rsi_pkg::RSI_WIDTH;
   localparam int IW  = rsi_pkg::RATIO_IDX_WIDTH;
   localparam logic [CW-1:0] DIV_LAST = CW'(DW - 1);

   // Sequencer states
   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_PREP = 3'd1;
   localparam logic [2:0] S_DIV  = 3'd2;
   localparam logic [2:0] S_FIX  = 3'd3;
   localparam logic [2:0] S_SUM  = 3'd4;
   localparam logic [2:0] S_RA   = 3'd5;
   localparam logic [2:0] S_RB   = 3'd6;
   localparam logic [2:0] S_OUT  = 3'd7;

   logic [2:0]    state_ff, state_in;
   logic [NW-1:0] period_ff, period_in;
   logic [PW-1:0] prev_ff, prev_in;
   logic          have_ff, have_in;
   logic [NW-1:0] count_ff, count_in;
   logic [AW-1:0] gacc_ff, gacc_in;
   logic [AW-1:0] lacc_ff, lacc_in;
   logic [PW-1:0] gain_ff, gain_in;
   logic [PW-1:0] loss_ff, loss_in;
   logic          init_ff, init_in;
   logic          sel_ff, sel_in;
   logic          neg_ff, neg_in;
   logic [DW-1:0] n_ff, n_in;
   logic [UW-1:0] rem_ff, rem_in;
   logic [RW-1:0] q_ff, q_in;
   logic [IW-1:0] idx_ff, idx_in;
   logic [CW-1:0] step_ff, step_in;
   logic [AW:0]   s_ff, s_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [RW-1:0] rsp_data_ff, rsp_data_in;

   // Shared unit operands
   logic [UW-1:0] op_a, op_b, op_diff;
   logic          op_ge;

   logic [NW-1:0]   p_eff;
   logic [PW-1:0]   price_w, gain_w, loss_w;
   logic            up_w;
   logic [NW-1:0]   count_next;
   logic [AW-1:0]   acc_sel;
   logic [PW-1:0]   x_sel;
   logic [AW+FW-1:0] sum_shift;
   logic [AW-1:0]   xs_ext;
   logic [AW-1:0]   dev_w;
   logic [AW-1:0]   quot_w;
   logic [AW-1:0]   acc_new;
   logic            out_free;

   rsi_csub #(.W(UW)) u_csub (
      .a    (op_a),
      .b    (op_b),
      .diff (op_diff),
      .ge   (op_ge)
   );

   assign p_eff     = (period_ff == '0) ? NW'(1) : period_ff;
   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_rsi_value = rsp_data_ff;
   assign out_free  = ~rsp_valid_ff | rsp_ready;

   // Price change split into gain and loss
   assign price_w    = req_price[PW-1:0];
   assign up_w       = price_w > prev_ff;
   assign gain_w     = up_w ? price_w - prev_ff : '0;
   assign loss_w     = up_w ? '0 : prev_ff - price_w;
   assign count_next = count_ff + NW'(1);

   // Accumulator under work and its new sample
   assign acc_sel   = sel_ff ? lacc_ff : gacc_ff;
   assign x_sel     = sel_ff ? loss_ff : gain_ff;
   assign sum_shift = {acc_sel, {FW{1'b0}}};
   assign xs_ext    = AW'({x_sel, {FW{1'b0}}});
   assign dev_w     = op_ge ? op_diff[AW-1:0] : acc_sel - xs_ext;
   assign quot_w    = n_ff[AW-1:0];

   // Average update: first average, or smoothing step up or down
   always_comb begin
      if (init_ff) begin
         acc_new = quot_w;
      end else if (neg_ff) begin
         acc_new = acc_sel - quot_w - AW'(rem_ff != '0);
      end else begin
         acc_new = acc_sel + quot_w;
      end
   end

   // Operand select for the shared unit
   always_comb begin
      op_a = '0;
      op_b = '0;
      unique case (state_ff)
         S_PREP: begin
            op_a = UW'(xs_ext);
            op_b = UW'(acc_sel);
         end
         S_DIV: begin
            op_a = {rem_ff[UW-2:0], n_ff[DW-1]};
            op_b = UW'(p_eff);
         end
         S_RA: begin
            op_a = {rem_ff[UW-2:0], 1'b0};
            op_b = UW'(s_ff);
         end
         S_RB: begin
            op_a = rem_ff;
            op_b = UW'(lacc_ff);
         end
         default: begin
            op_a = '0;
            op_b = '0;
         end
      endcase
   end

   // Sequencer and datapath next state
   always_comb begin
      state_in     = state_ff;
      period_in    = period_ff;
      prev_in      = prev_ff;
      have_in      = have_ff;
      count_in     = count_ff;
      gacc_in      = gacc_ff;
      lacc_in      = lacc_ff;
      gain_in      = gain_ff;
      loss_in      = loss_ff;
      init_in      = init_ff;
      sel_in       = sel_ff;
      neg_in       = neg_ff;
      n_in         = n_ff;
      rem_in       = rem_ff;
      q_in         = q_ff;
      idx_in       = idx_ff;
      step_in      = step_ff;
      s_in         = s_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_ready;
      rsp_data_in  = rsp_data_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               prev_in = price_w;
               if (req_series_start || !have_ff) begin
                  have_in  = 1'b1;
                  count_in = '0;
                  gacc_in  = '0;
                  lacc_in  = '0;
               end else begin
                  gain_in = gain_w;
                  loss_in = loss_w;
                  sel_in  = 1'b0;
                  if (count_ff < p_eff) begin
                     // warm-up: raw sums
                     gacc_in  = gacc_ff + AW'(gain_w);
                     lacc_in  = lacc_ff + AW'(loss_w);
                     count_in = count_next;
                     if (count_next == p_eff) begin
                        init_in  = 1'b1;
                        state_in = S_PREP;
                     end
                  end else begin
                     init_in  = 1'b0;
                     state_in = S_PREP;
                  end
               end
            end
         end
         S_PREP: begin
            // load dividend: sum * 2^F, or |x * 2^F - avg|
            if (init_ff) begin
               n_in = sum_shift[DW-1:0];
            end else begin
               n_in = {{(DW-AW){1'b0}}, dev_w};
            end
            neg_in   = ~op_ge;
            rem_in   = '0;
            step_in  = '0;
            state_in = S_DIV;
         end
         S_DIV: begin
            // one restoring step per cycle
            rem_in  = op_ge ? op_diff : op_a;
            n_in    = {n_ff[DW-2:0], op_ge};
            step_in = step_ff + CW'(1);
            if (step_ff == DIV_LAST) begin
               state_in = S_FIX;
            end
         end
         S_FIX: begin
            if (sel_ff) begin
               lacc_in  = acc_new;
               state_in = S_SUM;
            end else begin
               gacc_in  = acc_new;
               sel_in   = 1'b1;
               state_in = S_PREP;
            end
         end
         S_SUM: begin
            s_in   = {1'b0, gacc_ff} + {1'b0, lacc_ff};
            rem_in = '0;
            idx_in = rsi_pkg::RATIO_TOP;
            if (lacc_ff == '0) begin
               q_in     = rsi_pkg::RSI_SCALE;
               state_in = S_OUT;
            end else begin
               q_in     = '0;
               state_in = S_RA;
            end
         end
         S_RA: begin
            // doubling step of the ratio
            rem_in = op_ge ? op_diff : op_a;
            q_in   = {q_ff[RW-2:0], op_ge};
            if (rsi_pkg::RSI_SCALE[idx_ff]) begin
               state_in = S_RB;
            end else if (idx_ff == '0) begin
               state_in = S_OUT;
            end else begin
               idx_in = idx_ff - IW'(1);
            end
         end
         S_RB: begin
            // add G; r + G >= G + L is r >= L
            if (op_ge) begin
               rem_in = op_diff;
               q_in   = q_ff + RW'(1);
            end else begin
               rem_in = rem_ff + UW'(gacc_ff);
            end
            if (idx_ff == '0) begin
               state_in = S_OUT;
            end else begin
               idx_in   = idx_ff - IW'(1);
               state_in = S_RA;
            end
         end
         S_OUT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = q_ff;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      // Period write restarts the series
      if (csr_write_enable) begin
         period_in = csr_write_data;
         have_in   = 1'b0;
         count_in  = '0;
         gacc_in   = '0;
         lacc_in   = '0;
         prev_in   = '0;
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         period_ff    <= rsi_pkg::PERIOD_RESET;
         prev_ff      <= '0;
         have_ff      <= 1'b0;
         count_ff     <= '0;
         gacc_ff      <= '0;
         lacc_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         period_ff    <= period_in;
         prev_ff      <= prev_in;
         have_ff      <= have_in;
         count_ff     <= count_in;
         gacc_ff      <= gacc_in;
         lacc_ff      <= lacc_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Datapath registers
   always_ff @(posedge clock) begin
      gain_ff     <= gain_in;
      loss_ff     <= loss_in;
      init_ff     <= init_in;
      sel_ff      <= sel_in;
      neg_ff      <= neg_in;
      n_ff        <= n_in;
      rem_ff      <= rem_in;
      q_ff        <= q_in;
      idx_ff      <= idx_in;
      step_ff     <= step_in;
      s_ff        <= s_in;
      rsp_data_ff <= rsp_data_in;
   end

   // Checks
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= p_eff)
      else $error("change count beyond period");

   a_div_rem: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DIV) |-> (rem_ff < UW'(p_eff)))
      else $error("division remainder not below period");

   a_ratio_rem: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_RA || state_ff == S_RB) |-> (rem_ff < UW'(s_ff)))
      else $error("ratio remainder not below total");

   a_out_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_OUT && out_free) |=> (rsp_valid_ff && rsp_data_ff <= rsi_pkg::RSI_SCALE))
      else $error("result missing or out of range");

endmodule
